[rtl/core/tdt_pkg.sv]
// Package for the two-class delimiter tokenizer: item types, register
// layout, result codes and the delimiter match functions.
// No dependencies.
`timescale 1ns / 1ps

package tdt_pkg;

  // Two-character delimiter slots provided
  localparam int PAIR_SLOTS = 4;
  // Most results one input item can cause
  localparam int MAX_RESULTS = 4;

  // Result kinds
  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_END_TOKEN = 2'd1;
  localparam logic [1:0] KIND_END_LINE  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_SINGLE_LOW  = 2'd0;
  localparam logic [1:0] REG_SINGLE_HIGH = 2'd1;
  localparam logic [1:0] REG_PAIR_DELIMS = 2'd2;
  localparam logic [1:0] REG_PAIR_COUNT  = 2'd3;

  // Character constants
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_X         = 8'h58;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
  } out_item_t;

  typedef struct packed {
    logic [63:0] single_delims_low;
    logic [31:0] single_delims_high;
    logic [63:0] pair_delims;
    logic [2:0]  pair_count;
  } cfg_t;

  // Results of one item, in order, and how many are valid
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] items;
    logic [2:0]                  count;
  } result_set_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
  endfunction

  function automatic logic is_single(input cfg_t cfg, input logic [7:0] c);
    logic [6:0] offs;
    logic       hit;
    offs = c[6:0] - 7'd32;
    hit  = 1'b0;
    if (c == CHAR_X || c[7] || c[6:5] == 2'b00) begin
      hit = 1'b0;
    end else if (c[6:5] == 2'b11) begin
      hit = cfg.single_delims_high[c[4:0]];
    end else begin
      hit = cfg.single_delims_low[offs[5:0]];
    end
    return hit;
  endfunction

  function automatic logic is_pair(input cfg_t cfg, input logic [7:0] first,
                                   input logic [7:0] second);
    logic [2:0] used;
    logic [7:0] a;
    logic [7:0] b;
    logic       hit;
    used = (cfg.pair_count > 3'(PAIR_SLOTS)) ? 3'(PAIR_SLOTS) : cfg.pair_count;
    hit  = 1'b0;
    for (int k = 0; k < PAIR_SLOTS; k++) begin
      a = cfg.pair_delims[16*k+8 +: 8];
      b = cfg.pair_delims[16*k +: 8];
      if ((3'(k) < used) && (a != CHAR_X) && (first == a) && (second == b)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

[rtl/core/two_class_delimiter_tokenizer_top.sv]
// Two-class delimiter tokenizer: one line of characters in, token
// characters and end-of-token / end-of-line marks out.
// Results a character causes enter the result register when the next item
// is accepted (one character of lookahead); line-end results when the line-end item is.
// Throughput: one item per cycle while out_stall is low and each causes at most
// one result; an item with more (up to 4) holds the result port until all are out.
// Reset (rst, synchronous): clears registers, scanner state and result register.
`timescale 1ns / 1ps

module two_class_delimiter_tokenizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tdt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tdt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  tdt_pkg::cfg_t        cfg;
  tdt_pkg::result_set_t results;
  logic                 room;
  logic                 accept;

  // Take an item when the result register frees up
  assign in_stall = !room;
  assign accept   = in_valid && room;

  tdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdt_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .in_item (in_data),
    .results (results)
  );

  tdt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .results   (results),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/tdt_cfg.sv]
// Configuration register file of the tokenizer.
// Depends on tdt_pkg for the register layout and indexes.
`timescale 1ns / 1ps

module tdt_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output tdt_pkg::cfg_t cfg
);

  // Write the addressed register; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tdt_pkg::REG_SINGLE_LOW:  cfg.single_delims_low  <= cfg_data;
        tdt_pkg::REG_SINGLE_HIGH: cfg.single_delims_high <= cfg_data[31:0];
        tdt_pkg::REG_PAIR_DELIMS: cfg.pair_delims        <= cfg_data;
        tdt_pkg::REG_PAIR_COUNT:  cfg.pair_count         <= cfg_data[2:0];
        default:                  cfg                    <= cfg;
      endcase
    end
  end

endmodule

[rtl/core/tdt_scan.sv]
// Scanner of the tokenizer: lookahead register, token state and the
// single-pass decision that turns one input item into its result set.
// Depends on tdt_pkg for types, codes and delimiter matching.
`timescale 1ns / 1ps

module tdt_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  tdt_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  tdt_pkg::in_item_t    in_item,
  output tdt_pkg::result_set_t results
);

  logic [7:0] held_char;
  logic       held_valid;
  logic       inside_token;
  logic       escape_mode;
  logic       pair_second_pending;

  logic [7:0] held_char_next;
  logic       held_valid_next;
  logic       inside_token_next;
  logic       escape_mode_next;
  logic       pair_second_pending_next;

  logic       la_ok;
  logic       pair_hit;
  logic       single_hit;
  logic       space_hit;
  logic       do_begin;

  // Match the held character against the delimiter classes
  always_comb begin
    la_ok      = !in_item.line_end;
    pair_hit   = la_ok && tdt_pkg::is_pair(cfg, held_char, in_item.ch);
    single_hit = tdt_pkg::is_single(cfg, held_char);
    space_hit  = tdt_pkg::is_space(held_char);
  end

  // Decide the held character, then close the line or take the new one
  always_comb begin
    results                  = '0;
    held_char_next           = held_char;
    held_valid_next          = held_valid;
    inside_token_next        = inside_token;
    escape_mode_next         = escape_mode;
    pair_second_pending_next = pair_second_pending;
    do_begin                 = 1'b0;

    if (held_valid) begin
      if (pair_second_pending) begin
        results.items[results.count[1:0]] = {tdt_pkg::KIND_CHAR, held_char};
        results.count = results.count + 3'd1;
        results.items[results.count[1:0]] = {tdt_pkg::KIND_END_TOKEN, 8'h00};
        results.count = results.count + 3'd1;
        pair_second_pending_next = 1'b0;
        inside_token_next        = 1'b0;
      end else if (escape_mode) begin
        results.items[results.count[1:0]] = {tdt_pkg::KIND_CHAR, held_char};
        results.count = results.count + 3'd1;
        if (held_char == tdt_pkg::CHAR_SPACE) begin
          escape_mode_next = 1'b0;
        end
      end else if (inside_token) begin
        if (pair_hit || single_hit || space_hit) begin
          results.items[results.count[1:0]] = {tdt_pkg::KIND_END_TOKEN, 8'h00};
          results.count = results.count + 3'd1;
          inside_token_next = 1'b0;
          do_begin          = 1'b1;
        end else begin
          results.items[results.count[1:0]] = {tdt_pkg::KIND_CHAR, held_char};
          results.count = results.count + 3'd1;
        end
      end else begin
        do_begin = 1'b1;
      end

      // Open a new token at the held character; whitespace is dropped
      if (do_begin && !space_hit) begin
        results.items[results.count[1:0]] = {tdt_pkg::KIND_CHAR, held_char};
        results.count = results.count + 3'd1;
        if (held_char == tdt_pkg::CHAR_BACKSLASH) begin
          inside_token_next = 1'b1;
          escape_mode_next  = 1'b1;
        end else if (pair_hit) begin
          inside_token_next        = 1'b1;
          pair_second_pending_next = 1'b1;
        end else if (single_hit) begin
          results.items[results.count[1:0]] = {tdt_pkg::KIND_END_TOKEN, 8'h00};
          results.count = results.count + 3'd1;
        end else begin
          inside_token_next = 1'b1;
        end
      end
    end

    if (in_item.line_end) begin
      if (inside_token_next) begin
        results.items[results.count[1:0]] = {tdt_pkg::KIND_END_TOKEN, 8'h00};
        results.count = results.count + 3'd1;
      end
      results.items[results.count[1:0]] = {tdt_pkg::KIND_END_LINE, 8'h00};
      results.count = results.count + 3'd1;
      held_char_next           = 8'h00;
      held_valid_next          = 1'b0;
      inside_token_next        = 1'b0;
      escape_mode_next         = 1'b0;
      pair_second_pending_next = 1'b0;
    end else begin
      held_char_next  = in_item.ch;
      held_valid_next = 1'b1;
    end
  end

  // Advance the scanner state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      held_char           <= 8'h00;
      held_valid          <= 1'b0;
      inside_token        <= 1'b0;
      escape_mode         <= 1'b0;
      pair_second_pending <= 1'b0;
    end else if (accept) begin
      held_char           <= held_char_next;
      held_valid          <= held_valid_next;
      inside_token        <= inside_token_next;
      escape_mode         <= escape_mode_next;
      pair_second_pending <= pair_second_pending_next;
    end
  end

endmodule

[rtl/core/tdt_outbuf.sv]
// Result register of the tokenizer: holds the result set of one item and
// hands its items out one per cycle while out_stall is low. Depends on tdt_pkg for the types.
`timescale 1ns / 1ps

module tdt_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  tdt_pkg::result_set_t results,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tdt_pkg::out_item_t   out_data
);

  tdt_pkg::out_item_t [tdt_pkg::MAX_RESULTS-1:0] entries;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign out_data  = entries[0];
  assign pop       = out_valid && !out_stall;
  // Room for a new set once the last held item leaves this cycle
  assign room      = (count == 3'd0) || ((count == 3'd1) && !out_stall);

  // Track how many items are left to hand out
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (load) begin
      count <= results.count;
    end else if (pop) begin
      count <= count - 3'd1;
    end
  end

  // Load a fresh set, or shift the next item to the head
  always_ff @(posedge clk) begin
    if (load) begin
      entries <= results.items;
    end else if (pop) begin
      for (int i = 0; i < tdt_pkg::MAX_RESULTS - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

endmodule

[tb/two_class_delimiter_tokenizer_top_test.sv]
// Testbench for the two-class delimiter tokenizer: directed lines, then random lines
// under three idling settings, checked against an in-bench token predictor.
// Depends on tdt_pkg and two_class_delimiter_tokenizer_top.
`timescale 1ns / 1ps

module two_class_delimiter_tokenizer_top_test;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 8;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tdt_pkg::in_item_t   in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tdt_pkg::out_item_t  out_data;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = tdt_pkg::REG_SINGLE_LOW;
  logic [63:0]         cfg_data  = '0;

  // Idling percentages for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;

  // Predictor copy of the registers and the scanner
  logic [63:0] cfg_single_lo  = '0;
  logic [31:0] cfg_single_hi  = '0;
  logic [63:0] cfg_pairs      = '0;
  logic [2:0]  cfg_pair_count = '0;
  logic [7:0]  look_char      = '0;
  bit          look_full      = 1'b0;
  bit          in_token       = 1'b0;
  bit          escaping       = 1'b0;
  bit          pair_tail      = 1'b0;

  tdt_pkg::out_item_t expected_tokens[$];

  // Characters that make up most random lines
  string char_set = "ab=<>-;\\ X\t,z";

  two_class_delimiter_tokenizer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(logic [7:0] c);
    return c == tdt_pkg::CHAR_SPACE || c == tdt_pkg::CHAR_TAB ||
           c == tdt_pkg::CHAR_LF || c == tdt_pkg::CHAR_CR;
  endfunction

  function automatic bit single_hit(logic [7:0] c);
    if (c == tdt_pkg::CHAR_X) return 1'b0;
    if (c >= 8'd32 && c < 8'd96) return cfg_single_lo[c - 8'd32];
    if (c >= 8'd96 && c < 8'd128) return cfg_single_hi[c - 8'd96];
    return 1'b0;
  endfunction

  function automatic bit pair_hit(logic [7:0] first, logic [7:0] second);
    int used;
    used = (cfg_pair_count > tdt_pkg::PAIR_SLOTS) ? tdt_pkg::PAIR_SLOTS : cfg_pair_count;
    for (int k = 0; k < used; k++) begin
      if (cfg_pairs[16*k+8 +: 8] != tdt_pkg::CHAR_X && cfg_pairs[16*k+8 +: 8] == first &&
          cfg_pairs[16*k +: 8] == second) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_token(logic [1:0] k, logic [7:0] c);
    expected_tokens.push_back(tdt_pkg::out_item_t'{kind: k, out_char: c});
  endfunction

  // Open a token on the held character, or drop it when blank
  function automatic void start_token(logic [7:0] h, bit la_ok, logic [7:0] la);
    if (is_blank(h)) return;
    push_token(tdt_pkg::KIND_CHAR, h);
    if (h == tdt_pkg::CHAR_BACKSLASH) begin
      in_token = 1'b1;
      escaping = 1'b1;
    end else if (la_ok && pair_hit(h, la)) begin
      in_token  = 1'b1;
      pair_tail = 1'b1;
    end else if (single_hit(h)) begin
      push_token(tdt_pkg::KIND_END_TOKEN, 8'h00);
    end else begin
      in_token = 1'b1;
    end
  endfunction

  // Decide the held character now that its lookahead is known
  function automatic void settle_char(logic [7:0] h, bit la_ok, logic [7:0] la);
    if (pair_tail) begin
      push_token(tdt_pkg::KIND_CHAR, h);
      push_token(tdt_pkg::KIND_END_TOKEN, 8'h00);
      pair_tail = 1'b0;
      in_token  = 1'b0;
    end else if (escaping) begin
      push_token(tdt_pkg::KIND_CHAR, h);
      if (h == tdt_pkg::CHAR_SPACE) escaping = 1'b0;
    end else if (in_token) begin
      if ((la_ok && pair_hit(h, la)) || single_hit(h) || is_blank(h)) begin
        push_token(tdt_pkg::KIND_END_TOKEN, 8'h00);
        in_token = 1'b0;
        start_token(h, la_ok, la);
      end else begin
        push_token(tdt_pkg::KIND_CHAR, h);
      end
    end else begin
      start_token(h, la_ok, la);
    end
  endfunction

  function automatic void predict_item(tdt_pkg::in_item_t it);
    if (it.line_end) begin
      if (look_full) settle_char(look_char, 1'b0, 8'h00);
      if (in_token) push_token(tdt_pkg::KIND_END_TOKEN, 8'h00);
      push_token(tdt_pkg::KIND_END_LINE, 8'h00);
      look_char = '0;
      look_full = 1'b0;
      in_token  = 1'b0;
      escaping  = 1'b0;
      pair_tail = 1'b0;
    end else begin
      if (look_full) settle_char(look_char, 1'b1, it.ch);
      look_char = it.ch;
      look_full = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; predict on acceptance
  task automatic send_item(tdt_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(tdt_pkg::in_item_t'{ch: c, line_end: 1'b0});
  endtask

  task automatic send_line_end(logic [7:0] c);
    send_item(tdt_pkg::in_item_t'{ch: c, line_end: 1'b1});
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hold the sender until every expected token has arrived, then let it settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles; block must be idle
  task automatic write_config(logic [63:0] lo, logic [31:0] hi, logic [63:0] pairs,
                              logic [2:0] count);
    logic [1:0]  idx  [4];
    logic [63:0] vals [4];
    idx  = '{tdt_pkg::REG_SINGLE_LOW, tdt_pkg::REG_SINGLE_HIGH,
             tdt_pkg::REG_PAIR_DELIMS, tdt_pkg::REG_PAIR_COUNT};
    vals = '{lo, {32'd0, hi}, pairs, {61'd0, count}};
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_single_lo  = lo;
    cfg_single_hi  = hi;
    cfg_pairs      = pairs;
    cfg_pair_count = count;
  endtask

  function automatic logic [7:0] charset_pick();
    return char_set[$urandom_range(char_set.len() - 1)];
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(99) < 5) return 8'h00;
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return charset_pick();
  endfunction

  task automatic randomise_config();
    logic [63:0] lo;
    logic [31:0] hi;
    logic [63:0] pairs;
    logic [7:0]  c;
    lo = '0;
    hi = '0;
    case ($urandom_range(3))
      0: ;
      1: begin
        lo = '1;
        hi = '1;
      end
      2: begin
        lo = {$urandom, $urandom};
        hi = $urandom;
      end
      default: begin
        // Mark a few characters of the line alphabet
        repeat (4) begin
          c = charset_pick();
          if (c >= 8'd32 && c < 8'd96) lo[c - 8'd32] = 1'b1;
          else if (c >= 8'd96 && c < 8'd128) hi[c - 8'd96] = 1'b1;
        end
      end
    endcase
    for (int k = 0; k < tdt_pkg::PAIR_SLOTS; k++) begin
      pairs[16*k+8 +: 8] = charset_pick();
      pairs[16*k +: 8]   = ($urandom_range(7) == 0) ? 8'h00 : charset_pick();
    end
    write_config(lo, hi, pairs, 3'($urandom_range(7)));
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    tdt_pkg::out_item_t exp_tok;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: expected no token, got kind %0d char 0x%02h",
                 $time, out_data.kind, out_data.out_char);
        mismatches++;
      end else begin
        exp_tok = expected_tokens.pop_front();
        if (exp_tok.kind != out_data.kind || exp_tok.out_char != out_data.out_char) begin
          $display({"%0t: token mismatch, expected kind %0d char 0x%02h, ",
                    "got kind %0d char 0x%02h"},
                   $time, exp_tok.kind, exp_tok.out_char, out_data.kind, out_data.out_char);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: blanks split, escape runs past a space, odd bytes are plain
  task automatic test_whitespace_and_escape();
    send_text("\\a b");
    send_char(tdt_pkg::CHAR_TAB);
    send_char(8'h00);
    send_char(8'hFF);
    send_line_end(8'hA5);
    send_line_end(8'h00);
    wait_for_results();
  endtask

  // Every single delimiter set, pairs over all slots with an oversized count
  task automatic test_single_delimiters();
    write_config('1, '1, {"z", 8'h00, " ", "q", "X", "=", "<", "="}, 3'd7);
    send_text("a<=X\\c Xz");
    send_char(8'h00);
    send_text(" q");
    send_char(8'h7F);
    send_char("<");
    send_line_end("<");
    wait_for_results();
  endtask

  // Pair whose second character is a blank, no single delimiters
  task automatic test_pair_delimiters();
    write_config('0, '0, {48'd0, "-", " "}, 3'd1);
    send_text("a- b");
    send_line_end(8'h00);
    wait_for_results();
  endtask

  // Random lines over random register settings
  task automatic test_random_lines(int send_pct, int recv_pct, int n_items, bit pause_once);
    int sent;
    int line_len;
    bit paused;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(3) == 0) begin
        wait_for_results();
        randomise_config();
      end
      line_len = $urandom_range(12);
      for (int i = 0; i < line_len; i++) begin
        send_char(random_char());
        sent++;
        // Hold mid-line until the outstanding tokens have drained
        if (pause_once && !paused && i == 2) begin
          wait_for_results();
          paused = 1'b1;
        end
      end
      send_line_end(8'($urandom_range(255)));
      sent++;
    end
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 74;
    test_whitespace_and_escape();
    test_single_delimiters();
    test_pair_delimiters();
    test_random_lines(34, 74, 45, 1'b1);
    test_random_lines(74, 34, 45, 1'b0);
    test_random_lines(0, 0, 45, 1'b0);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tdt_pkg.sv
rtl/core/tdt_cfg.sv
rtl/core/tdt_scan.sv
rtl/core/tdt_outbuf.sv
rtl/core/two_class_delimiter_tokenizer_top.sv
tb/two_class_delimiter_tokenizer_top_test.sv
